FILE: sv/irqd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the interrupt distributor and CPU interface.
// Used by irqd_front, irqd_back and interrupt_distributor_cpu_interface.
package irqd_pkg;
   localparam int NumIrqs    = 64;
   localparam int Rows       = NumIrqs / 4;
   localparam int RowW       = $clog2(Rows);
   localparam int IdW        = $clog2(NumIrqs);
   localparam int BitWords   = NumIrqs / 32;
   localparam int LowTgtRows = 32 / 4;
   localparam logic [9:0] SpuriousId = 10'd1023;
   localparam logic [8:0] IdlePrio   = 9'd256;

   localparam logic [1:0] FiltList = 2'd0;
   localparam logic [1:0] FiltSelf = 2'd2;

   localparam logic [1:0] RegDistEn = 2'd0;
   localparam logic [1:0] RegCpuEn  = 2'd1;
   localparam logic [1:0] RegMask   = 2'd2;
   localparam logic [1:0] RegCpu    = 2'd3;

   typedef enum logic [3:0] {
      OP_SET_EN   = 4'd0,
      OP_CLR_EN   = 4'd1,
      OP_SET_PEND = 4'd2,
      OP_CLR_PEND = 4'd3,
      OP_PRIO_WR  = 4'd4,
      OP_TGT_WR   = 4'd5,
      OP_ACK      = 4'd6,
      OP_EOI      = 4'd7,
      OP_SOFT     = 4'd8,
      OP_RD_EN    = 4'd9,
      OP_RD_PEND  = 4'd10,
      OP_RD_PRIO  = 4'd11,
      OP_RD_TGT   = 4'd12,
      OP_LINE     = 4'd13,
      OP_NONE     = 4'd14
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  word;
      logic [31:0] data;
   } cmd_type;

   typedef struct packed {
      logic       dist_en;
      logic       cpu_en;
      logic [7:0] mask;
      logic [2:0] cpu;
   } cfg_type;
endpackage

FILE: sv/irqd_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, decodes the kind and holds them in a
// two-entry queue for the back end. Depends on irqd_pkg.
module irqd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [3:0]       req_tuser,
   input  logic [39:0]      req_tdata,
   output logic             q_valid,
   output irqd_pkg::cmd_type q_cmd,
   input  logic             q_pop
);
   irqd_pkg::cmd_type ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   irqd_pkg::op_type op;

   always_comb begin
      if (req_tuser inside {[irqd_pkg::OP_SET_EN:irqd_pkg::OP_LINE]}) begin
         op = irqd_pkg::op_type'(req_tuser);
      end else begin
         op = irqd_pkg::OP_NONE;
      end
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_cmd      = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= '{op: op, word: req_tdata[3:0], data: req_tdata[35:4]};
      end
   end

`ifndef SYNTH
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !req_tready) else $error("full queue accepts");
`endif
endmodule

FILE: sv/irqd_back.sv
`timescale 1ns / 1ps
// Back end: interrupt state, priority and target row memories, the
// row-by-row selection scan and the result register. Depends on irqd_pkg.
module irqd_back (
   input  logic              clock,
   input  logic              reset,
   input  irqd_pkg::cfg_type cfg,
   input  logic              q_valid,
   input  irqd_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_RDWAIT, ST_RUN, ST_SEL, ST_DONE
   } state_type;

   localparam int NumIrqs = irqd_pkg::NumIrqs;
   localparam int Rows    = irqd_pkg::Rows;
   localparam int RowW    = irqd_pkg::RowW;
   localparam int IdW     = irqd_pkg::IdW;

   state_type state_ff, state_in;
   irqd_pkg::cmd_type cmd_ff, cmd_in;
   logic [NumIrqs-1:0] en_ff, en_in, pend_ff, pend_in, act_ff, act_in;
   logic [Rows-1:0]    pvld_ff, pvld_in, tvld_ff, tvld_in;
   logic [31:0]        prio_mem [Rows];
   logic [31:0]        tgt_mem [Rows];
   logic [31:0]        prio_q_ff, tgt_q_ff;
   logic [RowW:0]      cnt_ff, cnt_in;
   logic [RowW-1:0]    row_ff, rd_addr;
   logic [8:0]         run_ff, run_in, best_ff, best_in;
   logic [IdW-1:0]     bid_ff, bid_in;
   logic               found_ff, found_in;
   logic [31:0]        rd_ff, rd_in;
   logic               out_vld_ff, out_vld_in;
   logic [39:0]        out_ff, out_in;
   logic               load;
   logic               word_in_rows;
   logic               prio_we, tgt_we;
   logic               hit_ok;

   logic [8:0]     run_nxt, best_nxt;
   logic [IdW-1:0] bid_nxt;
   logic           found_nxt;

   assign word_in_rows = (32'(cmd_ff.word) < Rows);
   assign prio_we = (state_ff == ST_EXEC) && (cmd_ff.op == irqd_pkg::OP_PRIO_WR) && word_in_rows;
   assign tgt_we  = (state_ff == ST_EXEC) && (cmd_ff.op == irqd_pkg::OP_TGT_WR) && word_in_rows
                    && (32'(cmd_ff.word) >= irqd_pkg::LowTgtRows);
   assign rd_addr = (state_ff == ST_EXEC) ? cmd_ff.word[RowW-1:0] : cnt_ff[RowW-1:0];
   assign hit_ok  = found_ff && cfg.dist_en && cfg.cpu_en;
   assign load    = (state_ff == ST_DONE) && (!out_vld_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (prio_we) begin
         prio_mem[cmd_ff.word[RowW-1:0]] <= cmd_ff.data;
      end
      if (tgt_we) begin
         tgt_mem[cmd_ff.word[RowW-1:0]] <= cmd_ff.data;
      end
      prio_q_ff <= pvld_ff[rd_addr] ? prio_mem[rd_addr] : 32'd0;
      tgt_q_ff  <= tvld_ff[rd_addr] ? tgt_mem[rd_addr] : 32'd0;
   end

   always_comb begin
      logic [IdW-1:0] id;
      logic [7:0]     p, t;
      logic           qual;
      run_nxt   = run_ff;
      best_nxt  = best_ff;
      bid_nxt   = bid_ff;
      found_nxt = found_ff;
      for (int k = 0; k < 4; k++) begin
         id = {row_ff, 2'(k)};
         p  = prio_q_ff[8*k +: 8];
         t  = tgt_q_ff[8*k +: 8];
         if (act_ff[id] && ({1'b0, p} < run_nxt)) begin
            run_nxt = {1'b0, p};
         end
         qual = en_ff[id] && pend_ff[id]
                && ((32'(row_ff) < irqd_pkg::LowTgtRows) || t[cfg.cpu])
                && (p < cfg.mask) && ({1'b0, p} < run_ff) && ({1'b0, p} < best_nxt);
         if (qual) begin
            best_nxt  = {1'b0, p};
            bid_nxt   = id;
            found_nxt = 1'b1;
         end
      end
   end

   always_comb begin
      logic [9:0] id10;
      logic       soft_hit;
      en_in   = en_ff;
      pend_in = pend_ff;
      act_in  = act_ff;
      pvld_in = pvld_ff;
      tvld_in = tvld_ff;
      id10    = cmd_ff.data[9:0];
      soft_hit = ((cmd_ff.data[25:24] == irqd_pkg::FiltList) && cmd_ff.data[16 + cfg.cpu])
                 || (cmd_ff.data[25:24] == irqd_pkg::FiltSelf);
      if (state_ff == ST_EXEC) begin
         for (int i = 0; i < NumIrqs; i++) begin
            if ((32'(cmd_ff.word) == (i >> 5)) && cmd_ff.data[i & 31]) begin
               case (cmd_ff.op)
                  irqd_pkg::OP_SET_EN:   en_in[i]   = 1'b1;
                  irqd_pkg::OP_CLR_EN:   en_in[i]   = 1'b0;
                  irqd_pkg::OP_SET_PEND: pend_in[i] = 1'b1;
                  irqd_pkg::OP_CLR_PEND: pend_in[i] = 1'b0;
                  default: ;
               endcase
            end
         end
         case (cmd_ff.op)
            irqd_pkg::OP_EOI:
               if (32'(id10) < NumIrqs) act_in[id10[IdW-1:0]] = 1'b0;
            irqd_pkg::OP_SOFT:
               if (soft_hit) pend_in[IdW'(cmd_ff.data[3:0])] = 1'b1;
            irqd_pkg::OP_LINE:
               if ((id10 >= 10'd16) && (32'(id10) < NumIrqs)) pend_in[id10[IdW-1:0]] = 1'b1;
            default: ;
         endcase
         if (prio_we) pvld_in[cmd_ff.word[RowW-1:0]] = 1'b1;
         if (tgt_we) tvld_in[cmd_ff.word[RowW-1:0]] = 1'b1;
      end
      if (load && (cmd_ff.op == irqd_pkg::OP_ACK) && hit_ok) begin
         act_in[bid_ff]  = 1'b1;
         pend_in[bid_ff] = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      best_in  = best_ff;
      bid_in   = bid_ff;
      found_in = found_ff;
      rd_in    = rd_ff;
      q_pop    = 1'b0;
      out_in   = out_ff;
      out_vld_in = (out_vld_ff && !rsp_tready) ? 1'b1 : 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rd_in  = 32'd0;
            run_in = irqd_pkg::IdlePrio;
            for (int w = 0; w < irqd_pkg::BitWords; w++) begin
               if (32'(cmd_ff.word) == w) begin
                  if (cmd_ff.op == irqd_pkg::OP_RD_EN) rd_in = en_ff[32*w +: 32];
                  if (cmd_ff.op == irqd_pkg::OP_RD_PEND) rd_in = pend_ff[32*w +: 32];
               end
            end
            if ((cmd_ff.op == irqd_pkg::OP_RD_PRIO) || (cmd_ff.op == irqd_pkg::OP_RD_TGT)) begin
               state_in = ST_RDWAIT;
            end else begin
               state_in = ST_RUN;
            end
         end
         ST_RDWAIT: begin
            if (!word_in_rows) begin
               rd_in = 32'd0;
            end else if (cmd_ff.op == irqd_pkg::OP_RD_PRIO) begin
               rd_in = prio_q_ff;
            end else if (32'(cmd_ff.word) < irqd_pkg::LowTgtRows) begin
               rd_in = {4{8'd1 << cfg.cpu}};
            end else begin
               rd_in = tgt_q_ff;
            end
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0) run_in = run_nxt;
            if (cnt_ff == (RowW+1)'(Rows)) begin
               cnt_in   = '0;
               best_in  = irqd_pkg::IdlePrio;
               found_in = 1'b0;
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               best_in  = best_nxt;
               bid_in   = bid_nxt;
               found_in = found_nxt;
            end
            if (cnt_ff == (RowW+1)'(Rows)) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               out_vld_in = 1'b1;
               if (cmd_ff.op == irqd_pkg::OP_ACK) begin
                  out_in = {8'd0, 32'(hit_ok ? 10'(bid_ff) : irqd_pkg::SpuriousId)};
               end else begin
                  out_in = {7'd0, hit_ok, rd_ff};
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         out_vld_ff <= 1'b0;
         en_ff      <= '0;
         pend_ff    <= '0;
         act_ff     <= '0;
         pvld_ff    <= '0;
         tvld_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         out_vld_ff <= out_vld_in;
         en_ff      <= en_in;
         pend_ff    <= pend_in;
         act_ff     <= act_in;
         pvld_ff    <= pvld_in;
         tvld_ff    <= tvld_in;
      end
      cmd_ff   <= cmd_in;
      row_ff   <= cnt_ff[RowW-1:0];
      run_ff   <= run_in;
      best_ff  <= best_in;
      bid_ff   <= bid_in;
      found_ff <= found_in;
      rd_ff    <= rd_in;
      out_ff   <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

`ifndef SYNTH
   a_ack_no_req: assert property (@(posedge clock) disable iff (reset)
      (load && (cmd_ff.op == irqd_pkg::OP_ACK)) |=> !rsp_tdata[32])
      else $error("acknowledge result signals a request");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (RowW+1)'(Rows)) else $error("scan count overrun");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE)) else $error("pop while busy");
`endif
endmodule

FILE: sv/interrupt_distributor_cpu_interface.sv
`timescale 1ns / 1ps
// Top level of the interrupt distributor and CPU interface: control
// registers and the front and back ends. Depends on irqd_pkg, irqd_front, irqd_back.
//
//   channel  | direction | contents
//   req_     | in        | one bus access or source pulse
//   rsp_     | out       | read data and interrupt request line
//   csr_     | in/out    | enables, priority mask, CPU number
//
// Each request passes through the back end in order: pop, decode and state update
// (plus a memory read wait for priority and target reads), two passes over the 16
// memory rows (running priority, then selection) and the load of the result register.
// The two-entry queue keeps taking requests while the back end works; a held
// response stalls the back end in its last state and then fills the queue.
// Reset is synchronous and clears all interrupt state at once.
module interrupt_distributor_cpu_interface (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // word_index[3:0], write_data[35:4], zero pad
   input  logic [3:0]  req_tuser,  // kind[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // read_data[31:0], interrupt_request[32], zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   irqd_pkg::cfg_type cfg_ff, cfg_in;
   irqd_pkg::cmd_type q_cmd;
   logic q_valid, q_pop, wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            irqd_pkg::RegDistEn: cfg_in.dist_en = csr_pwdata[0];
            irqd_pkg::RegCpuEn:  cfg_in.cpu_en  = csr_pwdata[0];
            irqd_pkg::RegMask:   cfg_in.mask    = csr_pwdata[7:0];
            irqd_pkg::RegCpu:    cfg_in.cpu     = csr_pwdata[2:0];
            default: ;
         endcase
      end
      case (csr_paddr[3:2])
         irqd_pkg::RegDistEn: csr_prdata = {31'd0, cfg_ff.dist_en};
         irqd_pkg::RegCpuEn:  csr_prdata = {31'd0, cfg_ff.cpu_en};
         irqd_pkg::RegMask:   csr_prdata = {24'd0, cfg_ff.mask};
         irqd_pkg::RegCpu:    csr_prdata = {29'd0, cfg_ff.cpu};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   irqd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop)
   );

   irqd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule
